### rtl/bqsf_pkg.sv
// Package for the biquadratic shape function unit.
// Holds fixed field widths, opcodes, node factor tables and shared types.
// No dependencies.
package bqsf_pkg;

    // Fixed field widths
    localparam int IN_W  = 16;
    localparam int OUT_W = 18;
    localparam int SQ_W  = 2 * IN_W;
    localparam int NODES = 9;

    // Output saturation limits
    localparam int OUT_MAX = 131071;
    localparam int OUT_MIN = -131072;

    // Opcodes
    localparam logic [1:0] OP_DCSI  = 2'd1;
    localparam logic [1:0] OP_DETA  = 2'd2;
    localparam logic [1:0] OP_DZETA = 2'd3;

    typedef logic [1:0]                opcode_t;
    typedef logic signed [IN_W-1:0]    coord_t;
    typedef logic signed [OUT_W-1:0]   node_t;
    typedef logic signed [SQ_W-1:0]    square_t;
    typedef logic [1:0]                fsel_t;

    // Per-coordinate factor control: derivative instead of value, or force zero
    typedef struct packed {
        logic deriv;
        logic zero;
    } factor_ctl_t;

    // One-dimensional factor index per node, csi side and eta side
    localparam fsel_t CSI_SEL [NODES] = '{2'd0, 2'd2, 2'd2, 2'd0, 2'd1, 2'd2, 2'd1, 2'd0, 2'd1};
    localparam fsel_t ETA_SEL [NODES] = '{2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd1, 2'd2, 2'd1, 2'd1};

    // Width of a rounded 1-D factor: |L| <= 2^(30-F) + 2^F + 1, |D| <= 2^16
    function automatic int factor_w(input int frac);
        int big;
        big = (30 - frac > frac) ? (30 - frac) : frac;
        return big + 3;
    endfunction

endpackage

### rtl/bqsf_if.sv
// Handshake channel interfaces for the biquadratic shape function unit.
// Depends on bqsf_pkg for payload types.

// Input channel: opcode and natural coordinates
interface bqsf_in_if import bqsf_pkg::*; ();
    logic    valid;
    logic    ready;
    opcode_t opcode;
    coord_t  csi;
    coord_t  eta;

    modport source (output valid, output opcode, output csi, output eta, input ready);
    modport sink   (input valid, input opcode, input csi, input eta, output ready);
endinterface

// Result channel: one value per node
interface bqsf_out_if import bqsf_pkg::*; ();
    logic  valid;
    logic  ready;
    node_t node0;
    node_t node1;
    node_t node2;
    node_t node3;
    node_t node4;
    node_t node5;
    node_t node6;
    node_t node7;
    node_t node8;

    modport source (output valid, input ready, output node0, output node1, output node2,
                    output node3, output node4, output node5, output node6, output node7,
                    output node8);
    modport sink   (input valid, output ready, input node0, input node1, input node2,
                    input node3, input node4, input node5, input node6, input node7,
                    input node8);
endinterface

### rtl/bqsf_square.sv
// Stage 1 of the shape function pipeline: squares of both coordinates.
// Depends on bqsf_pkg.
module bqsf_square import bqsf_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  opcode_t opcode,
    input  coord_t  csi,
    input  coord_t  eta,
    output opcode_t op_reg,
    output coord_t  csi_reg,
    output coord_t  eta_reg,
    output square_t sq_csi_reg,
    output square_t sq_eta_reg
);

    square_t sq_csi_next;
    square_t sq_eta_next;

    // One 16x16 multiplier per coordinate
    assign sq_csi_next = SQ_W'(csi) * SQ_W'(csi);
    assign sq_eta_next = SQ_W'(eta) * SQ_W'(eta);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg     <= opcode;
            csi_reg    <= csi;
            eta_reg    <= eta;
            sq_csi_reg <= sq_csi_next;
            sq_eta_reg <= sq_eta_next;
        end
    end

endmodule

### rtl/bqsf_factor.sv
// Stage 2: the three one-dimensional factors of one coordinate.
// Lagrange values L0, L1, L2 or derivatives D0, D1, D2, rounded. Depends on bqsf_pkg.
module bqsf_factor import bqsf_pkg::*;
#(
    parameter int FRAC_BITS = 14,
    parameter int FW        = factor_w(FRAC_BITS)
)
(
    input  logic                 clk,
    input  logic                 en,
    input  factor_ctl_t          ctl,
    input  coord_t               x,
    input  square_t              sq,
    output logic signed [FW-1:0] fac_reg [3]
);

    localparam int NW = 2 * FRAC_BITS + 20;

    // Round to nearest, ties away from zero: (v + h - sign) >>> k
    function automatic logic signed [NW-1:0] rnd(input logic signed [NW-1:0] v, input int k);
        logic signed [NW-1:0] h;
        logic signed [NW-1:0] s;
        h = NW'(1) << (k - 1);
        s = {{(NW-1){1'b0}}, v[NW-1]};
        return (v + h - s) >>> k;
    endfunction

    logic signed [NW-1:0] sq_w;
    logic signed [NW-1:0] xf_w;
    logic signed [NW-1:0] one2_w;
    logic signed [NW-1:0] l0_w;
    logic signed [NW-1:0] l1_w;
    logic signed [NW-1:0] l2_w;
    logic signed [FW-1:0] x_f;
    logic signed [FW-1:0] half_f;
    logic signed [FW-1:0] fac_next [3];

    // Numerators x^2 -/+ x*one and one^2 - x^2
    assign sq_w   = {{(NW-SQ_W){sq[SQ_W-1]}}, sq};
    assign xf_w   = {{(NW-IN_W){x[IN_W-1]}}, x} <<< FRAC_BITS;
    assign one2_w = NW'(1) << (2 * FRAC_BITS);

    assign l0_w = rnd(sq_w - xf_w, FRAC_BITS + 1);
    assign l2_w = rnd(sq_w + xf_w, FRAC_BITS + 1);
    assign l1_w = rnd(one2_w - sq_w, FRAC_BITS);

    // Derivatives are exact
    assign x_f    = {{(FW-IN_W){x[IN_W-1]}}, x};
    assign half_f = FW'(1) << (FRAC_BITS - 1);

    // Factor selection
    always_comb
    begin
        priority if (ctl.zero)
        begin
            fac_next[0] = '0;
            fac_next[1] = '0;
            fac_next[2] = '0;
        end
        else if (ctl.deriv)
        begin
            fac_next[0] = x_f - half_f;
            fac_next[1] = -(x_f <<< 1);
            fac_next[2] = x_f + half_f;
        end
        else
        begin
            fac_next[0] = l0_w[FW-1:0];
            fac_next[1] = l1_w[FW-1:0];
            fac_next[2] = l2_w[FW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fac_reg[0] <= fac_next[0];
            fac_reg[1] <= fac_next[1];
            fac_reg[2] <= fac_next[2];
        end
    end

endmodule

### rtl/bqsf_node.sv
// Stages 3 and 4 for one node: factor product, then rounding and saturation.
// Depends on bqsf_pkg.
module bqsf_node import bqsf_pkg::*;
#(
    parameter int FRAC_BITS = 14,
    parameter int FW        = factor_w(FRAC_BITS)
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [FW-1:0] a,
    input  logic signed [FW-1:0] b,
    output node_t                node_reg
);

    localparam int PW = 2 * FW;
    localparam logic signed [PW-1:0] SAT_HI = PW'(OUT_MAX);
    localparam logic signed [PW-1:0] SAT_LO = PW'(OUT_MIN);
    localparam logic signed [PW-1:0] HALF   = PW'(1) << (FRAC_BITS - 1);

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] rnd_w;
    node_t                node_next;

    assign prod_next = PW'(a) * PW'(b);

    // Round to nearest, ties away from zero
    assign rnd_w = (prod_reg + HALF - $signed({{(PW-1){1'b0}}, prod_reg[PW-1]})) >>> FRAC_BITS;

    // Saturate to the result range
    always_comb
    begin
        priority if (rnd_w > SAT_HI)
            node_next = SAT_HI[OUT_W-1:0];
        else if (rnd_w < SAT_LO)
            node_next = SAT_LO[OUT_W-1:0];
        else
            node_next = rnd_w[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            node_reg <= node_next;
        end
    end

endmodule

### rtl/biquadratic_shape_functions_unit.sv
// Biquadratic (9-node) shape function unit: values and derivatives per point.
// Four register stages; throughput one item per cycle while the result is not stalled.
// Stages: coordinate squares, 1-D factor rounding, factor products, round and saturate.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n, async, active low) clears the stage valid bits only.
module biquadratic_shape_functions_unit import bqsf_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input  logic       clk,
    input  logic       rst_n,
    bqsf_in_if.sink    sample,
    bqsf_out_if.source result
);

    localparam int FW = factor_w(FRAC_BITS);

    logic        en;
    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic        v4_reg;
    opcode_t     op1;
    coord_t      csi1;
    coord_t      eta1;
    square_t     sq_csi1;
    square_t     sq_eta1;
    factor_ctl_t csi_ctl;
    factor_ctl_t eta_ctl;

    logic signed [FW-1:0] f_csi [3];
    logic signed [FW-1:0] f_eta [3];
    node_t                node_q [NODES];

    // Pipeline advances unless the result register is full and not taken
    assign en           = !v4_reg || result.ready;
    assign sample.ready = en;
    assign result.valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= sample.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage 1: squares
    bqsf_square u_square (
        .clk        (clk),
        .en         (en),
        .opcode     (sample.opcode),
        .csi        (sample.csi),
        .eta        (sample.eta),
        .op_reg     (op1),
        .csi_reg    (csi1),
        .eta_reg    (eta1),
        .sq_csi_reg (sq_csi1),
        .sq_eta_reg (sq_eta1)
    );

    // Opcode decode into factor control
    assign csi_ctl.deriv = (op1 == OP_DCSI);
    assign csi_ctl.zero  = (op1 == OP_DZETA);
    assign eta_ctl.deriv = (op1 == OP_DETA);
    assign eta_ctl.zero  = (op1 == OP_DZETA);

    // Stage 2: 1-D factors
    bqsf_factor #(.FRAC_BITS(FRAC_BITS), .FW(FW)) u_factor_csi (
        .clk     (clk),
        .en      (en),
        .ctl     (csi_ctl),
        .x       (csi1),
        .sq      (sq_csi1),
        .fac_reg (f_csi)
    );

    bqsf_factor #(.FRAC_BITS(FRAC_BITS), .FW(FW)) u_factor_eta (
        .clk     (clk),
        .en      (en),
        .ctl     (eta_ctl),
        .x       (eta1),
        .sq      (sq_eta1),
        .fac_reg (f_eta)
    );

    // Stages 3 and 4: one product lane per node
    for (genvar k = 0; k < NODES; k++)
    begin : g_node
        bqsf_node #(.FRAC_BITS(FRAC_BITS), .FW(FW)) u_node (
            .clk      (clk),
            .en       (en),
            .a        (f_csi[CSI_SEL[k]]),
            .b        (f_eta[ETA_SEL[k]]),
            .node_reg (node_q[k])
        );
    end

    assign result.node0 = node_q[0];
    assign result.node1 = node_q[1];
    assign result.node2 = node_q[2];
    assign result.node3 = node_q[3];
    assign result.node4 = node_q[4];
    assign result.node5 = node_q[5];
    assign result.node6 = node_q[6];
    assign result.node7 = node_q[7];
    assign result.node8 = node_q[8];

    // An input transfer fills stage 1 on the next cycle
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> v1_reg)
        else $error("input transfer did not reach stage 1");

    // A stalled result freezes the stage 1 to 3 valid bits
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> $stable({v1_reg, v2_reg, v3_reg}))
        else $error("pipeline moved during output stall");

    // Third-axis derivative zeroes all factors
    a_dzeta: assert property (@(posedge clk) disable iff (!rst_n)
        en && v1_reg && (op1 == OP_DZETA) |=>
            (f_csi[0] == '0) && (f_csi[1] == '0) && (f_csi[2] == '0) &&
            (f_eta[0] == '0) && (f_eta[1] == '0) && (f_eta[2] == '0))
        else $error("third-axis derivative factors not zero");

endmodule
